// File: hdl/thc_pkg.sv
`default_nettype none
package thc_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 24;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TEMP_CAL_ONE      = 4'd0,
		REG_TEMP_CAL_TWO      = 4'd1,
		REG_TEMP_CAL_THREE    = 4'd2,
		REG_HUM_CAL_ONE       = 4'd3,
		REG_HUM_CAL_TWO       = 4'd4,
		REG_HUM_CAL_THREE     = 4'd5,
		REG_HUM_CAL_FOUR_FIVE = 4'd6,
		REG_HUM_CAL_SIX       = 4'd7
	} cfg_reg_t;

	// compensation constants
	localparam logic [31:0] HUM_FINE_OFFSET = 32'd76800;
	localparam logic [31:0] HUM_X_ROUND     = 32'd16384;
	localparam logic [21:0] HUM_Y_OFFSET    = 22'd32768;
	localparam logic [22:0] HUM_Y_BIAS      = 23'd2097152;
	localparam logic [31:0] HUM_Y_ROUND     = 32'd8192;
	localparam logic [31:0] HUM_CLAMP       = 32'd419430400;
	localparam logic [16:0] HUM_MAX         = HUM_CLAMP[28:12];
	localparam logic [31:0] TEMP_ROUND      = 32'd128;
	localparam logic [31:0] TEMP_TRUNC_BIAS = 32'd255;

	// unpacked calibration set
	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [7:0]  h1;
		logic signed [15:0] h2;
		logic        [7:0]  h3;
		logic signed [11:0] h4;
		logic signed [11:0] h5;
		logic signed [7:0]  h6;
	} thc_cal_t;

	// hand-over from the temperature section to the humidity section
	typedef struct packed {
		logic        valid;
		logic [31:0] fine;
		logic [15:0] raw_humidity;
	} thc_mid_t;

	// one finished result
	typedef struct packed {
		logic [31:0] temperature;
		logic [31:0] fine_temperature;
		logic [16:0] humidity;
	} thc_out_t;

	typedef struct packed {
		logic     valid;
		thc_out_t data;
	} thc_res_t;

endpackage
`default_nettype wire

// File: hdl/temp_humidity_compensation.sv
// throughput: one request per cycle while the skid stage is empty, through sixteen
// register stages, four for temperature and twelve for humidity, each no deeper than
// one multiplier or one wide add, and then the output register, which with a one-entry
// skid stage keeps input flowing while a result waits, until the skid stage fills;
// reset clears all valid bits and calibration registers to zero
`default_nettype none
module temp_humidity_compensation
	import thc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [19:0]            raw_temperature,
	input  wire logic [15:0]            raw_humidity,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [31:0]          temperature,
	output logic signed [31:0]          fine_temperature,
	output logic [16:0]                 humidity,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	thc_cal_t cal;
	thc_mid_t mid;
	thc_res_t res;
	logic     en;

	logic     out_valid_q;
	logic     skid_valid_q;
	thc_out_t out_q;
	thc_out_t skid_q;

	assign cfg_ready = 1'b1;

	thc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cal      (cal)
	);

	thc_temp u_temp (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (in_valid),
		.raw_temperature (raw_temperature),
		.raw_humidity    (raw_humidity),
		.cal             (cal),
		.mid             (mid)
	);

	thc_hum u_hum (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.mid    (mid),
		.cal    (cal),
		.res    (res)
	);

	// pipeline advances while the skid stage is free
	assign en       = !skid_valid_q;
	assign in_ready = en;

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res.valid;
			end
		end else if (res.valid && en) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res.data;
		end else if (res.valid && en) begin
			skid_q <= res.data;
		end
	end

	assign out_valid        = out_valid_q;
	assign temperature      = out_q.temperature;
	assign fine_temperature = out_q.fine_temperature;
	assign humidity         = out_q.humidity;

endmodule
`default_nettype wire

// File: hdl/thc_cfg.sv
`default_nettype none
module thc_cfg
	import thc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire logic [CFG_INDEX_W-1:0] wr_index,
	input  wire logic [CFG_DATA_W-1:0]  wr_data,
	output thc_cal_t                    cal
);

	thc_cal_t cal_q;

	// calibration register file, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TEMP_CAL_ONE:   cal_q.t1 <= wr_data[15:0];
				REG_TEMP_CAL_TWO:   cal_q.t2 <= wr_data[15:0];
				REG_TEMP_CAL_THREE: cal_q.t3 <= wr_data[15:0];
				REG_HUM_CAL_ONE:    cal_q.h1 <= wr_data[7:0];
				REG_HUM_CAL_TWO:    cal_q.h2 <= wr_data[15:0];
				REG_HUM_CAL_THREE:  cal_q.h3 <= wr_data[7:0];
				REG_HUM_CAL_FOUR_FIVE: begin
					cal_q.h4 <= wr_data[23:12];
					cal_q.h5 <= wr_data[11:0];
				end
				REG_HUM_CAL_SIX:    cal_q.h6 <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cal = cal_q;

endmodule
`default_nettype wire

// File: hdl/thc_temp.sv
`default_nettype none
module thc_temp
	import thc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [19:0] raw_temperature,
	input  wire logic [15:0] raw_humidity,
	input  wire thc_cal_t    cal,
	output thc_mid_t         mid
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic signed [17:0] a_s1;
	logic signed [16:0] d_s1;
	logic signed [20:0] v1_s2, v1_s3;
	logic signed [19:0] dd_s2;
	logic signed [17:0] v2_s3;
	logic        [31:0] fine_s4;
	logic        [15:0] rh_s1, rh_s2, rh_s3, rh_s4;

	logic signed [17:0] a_n;
	logic signed [16:0] d_n;
	logic signed [33:0] p1;
	logic signed [33:0] pdd;
	logic signed [35:0] p3;
	logic signed [31:0] p1_lo, pdd_lo, p3_lo;
	logic signed [31:0] v1_sh, dd_sh, v2_sh;

	// offsets of the raw reading against T1
	always_comb begin
		a_n = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
		d_n = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
	end

	// linear term and square of the offset
	always_comb begin
		p1    = a_s1 * $signed(cal.t2);
		pdd   = d_s1 * d_s1;
		p1_lo = p1[31:0];
		pdd_lo = pdd[31:0];
		v1_sh = p1_lo >>> 11;
		dd_sh = pdd_lo >>> 12;
	end

	// quadratic term
	always_comb begin
		p3    = dd_s2 * $signed(cal.t3);
		p3_lo = p3[31:0];
		v2_sh = p3_lo >>> 14;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a_n;
			d_s1    <= d_n;
			rh_s1   <= raw_humidity;
			v1_s2   <= v1_sh[20:0];
			dd_s2   <= dd_sh[19:0];
			rh_s2   <= rh_s1;
			v1_s3   <= v1_s2;
			v2_s3   <= v2_sh[17:0];
			rh_s3   <= rh_s2;
			fine_s4 <= {{11{v1_s3[20]}}, v1_s3} + {{14{v2_s3[17]}}, v2_s3};
			rh_s4   <= rh_s3;
		end
	end

	assign mid.valid        = valid_s4;
	assign mid.fine         = fine_s4;
	assign mid.raw_humidity = rh_s4;

endmodule
`default_nettype wire

// File: hdl/thc_hum.sv
`default_nettype none
module thc_hum
	import thc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire thc_mid_t mid,
	input  wire thc_cal_t cal,
	output thc_res_t      res
);

	logic valid_s5, valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;
	logic valid_s11, valid_s12, valid_s13, valid_s14, valid_s15, valid_s16;

	// temperature results riding along
	logic [31:0] fine_s5, fine_s6, fine_s7, fine_s8, fine_s9, fine_s10;
	logic [31:0] fine_s11, fine_s12, fine_s13, fine_s14, fine_s15, fine_s16;
	logic [31:0] tsum_s5;
	logic signed [23:0] temp_s6, temp_s7, temp_s8, temp_s9, temp_s10, temp_s11;
	logic signed [23:0] temp_s12, temp_s13, temp_s14, temp_s15, temp_s16;

	// humidity datapath
	logic        [31:0] v_s5;
	logic        [31:0] base_s5, base_s6;
	logic        [31:0] m5_s6;
	logic signed [21:0] y1_s6, y1_s7;
	logic signed [20:0] m3_s6;
	logic signed [16:0] x_s7, x_s8, x_s9, x_s10, x_s11;
	logic signed [21:0] y2_s7;
	logic        [31:0] ym_s8;
	logic signed [22:0] yb_s9;
	logic        [31:0] yh_s10;
	logic signed [17:0] y_s11;
	logic        [31:0] vm_s12, vm_s13, vm_s14;
	logic        [31:0] ss_s13;
	logic        [31:0] q_s14;
	logic        [31:0] r_s15;
	logic        [16:0] hum_s16;

	logic        [31:0] tbias;
	logic signed [31:0] t_sh;
	logic signed [43:0] m5;
	logic signed [39:0] m6;
	logic signed [40:0] m3;
	logic signed [31:0] m6_lo, m3_lo, m6_sh, m3_sh;
	logic signed [31:0] xs, x_sh;
	logic signed [43:0] ym;
	logic signed [31:0] ym_sh;
	logic signed [38:0] yh;
	logic signed [31:0] yr, yr_sh;
	logic signed [34:0] vm;
	logic signed [31:0] s_sh;
	logic signed [16:0] s17;
	logic signed [33:0] ss;
	logic signed [31:0] q_sh;
	logic signed [24:0] q25;
	logic signed [33:0] q;
	logic signed [31:0] r_sh;

	// temperature rounding, truncated toward zero
	always_comb begin
		tbias = tsum_s5 + (tsum_s5[31] ? TEMP_TRUNC_BIAS : 32'd0);
		t_sh  = $signed(tbias) >>> 8;
	end

	// products of the temperature offset with H5, H6 and H3
	always_comb begin
		m5    = $signed(cal.h5) * $signed(v_s5);
		m6    = $signed(v_s5) * $signed(cal.h6);
		m3    = $signed(v_s5) * $signed({1'b0, cal.h3});
		m6_lo = m6[31:0];
		m3_lo = m3[31:0];
		m6_sh = m6_lo >>> 10;
		m3_sh = m3_lo >>> 11;
	end

	// raw humidity term
	always_comb begin
		xs   = base_s6 - m5_s6 + HUM_X_ROUND;
		x_sh = xs >>> 15;
	end

	// temperature dependent gain
	always_comb begin
		ym    = y1_s7 * y2_s7;
		ym_sh = $signed(ym_s8) >>> 10;
		yh    = yb_s9 * $signed(cal.h2);
		yr    = yh_s10 + HUM_Y_ROUND;
		yr_sh = yr >>> 14;
	end

	// gain applied, then the H1 correction
	always_comb begin
		vm   = x_s11 * y_s11;
		s_sh = $signed(vm_s12) >>> 15;
		s17  = s_sh[16:0];
		ss   = s17 * s17;
		q_sh = $signed(ss_s13) >>> 7;
		q25  = q_sh[24:0];
		q    = q25 * $signed({1'b0, cal.h1});
		r_sh = $signed(q_s14) >>> 4;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
			valid_s15 <= 1'b0;
			valid_s16 <= 1'b0;
		end else if (en) begin
			valid_s5  <= mid.valid;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
			valid_s14 <= valid_s13;
			valid_s15 <= valid_s14;
			valid_s16 <= valid_s15;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			// offset, temperature sum and humidity base
			v_s5    <= mid.fine - HUM_FINE_OFFSET;
			tsum_s5 <= {mid.fine[29:0], 2'b00} + mid.fine + TEMP_ROUND;
			base_s5 <= {2'b00, mid.raw_humidity, 14'd0} - {cal.h4, 20'd0};
			fine_s5 <= mid.fine;

			temp_s6 <= t_sh[23:0];
			m5_s6   <= m5[31:0];
			y1_s6   <= m6_sh[21:0];
			m3_s6   <= m3_sh[20:0];
			base_s6 <= base_s5;
			fine_s6 <= fine_s5;

			x_s7    <= x_sh[16:0];
			y1_s7   <= y1_s6;
			y2_s7   <= {m3_s6[20], m3_s6} + HUM_Y_OFFSET;
			temp_s7 <= temp_s6;
			fine_s7 <= fine_s6;

			ym_s8   <= ym[31:0];
			x_s8    <= x_s7;
			temp_s8 <= temp_s7;
			fine_s8 <= fine_s7;

			yb_s9   <= {ym_sh[21], ym_sh[21:0]} + HUM_Y_BIAS;
			x_s9    <= x_s8;
			temp_s9 <= temp_s8;
			fine_s9 <= fine_s8;

			yh_s10   <= yh[31:0];
			x_s10    <= x_s9;
			temp_s10 <= temp_s9;
			fine_s10 <= fine_s9;

			y_s11    <= yr_sh[17:0];
			x_s11    <= x_s10;
			temp_s11 <= temp_s10;
			fine_s11 <= fine_s10;

			vm_s12   <= vm[31:0];
			temp_s12 <= temp_s11;
			fine_s12 <= fine_s11;

			ss_s13   <= ss[31:0];
			vm_s13   <= vm_s12;
			temp_s13 <= temp_s12;
			fine_s13 <= fine_s12;

			q_s14    <= q[31:0];
			vm_s14   <= vm_s13;
			temp_s14 <= temp_s13;
			fine_s14 <= fine_s13;

			r_s15    <= vm_s14 - r_sh;
			temp_s15 <= temp_s14;
			fine_s15 <= fine_s14;

			// clamp to the valid humidity range and drop the fraction bits
			if (r_s15[31]) begin
				hum_s16 <= '0;
			end else if (r_s15 > HUM_CLAMP) begin
				hum_s16 <= HUM_MAX;
			end else begin
				hum_s16 <= r_s15[28:12];
			end
			temp_s16 <= temp_s15;
			fine_s16 <= fine_s15;
		end
	end

	assign res.valid                 = valid_s16;
	assign res.data.temperature      = {{8{temp_s16[23]}}, temp_s16};
	assign res.data.fine_temperature = fine_s16;
	assign res.data.humidity         = hum_s16;

endmodule
`default_nettype wire

// File: hdl/thc_checker.sv
`default_nettype none
module thc_checker
	import thc_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic [19:0]            raw_temperature,
	input wire logic [15:0]            raw_humidity,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic signed [31:0]     temperature,
	input wire logic signed [31:0]     fine_temperature,
	input wire logic [16:0]            humidity,
	input wire logic                   cfg_valid,
	input wire logic                   cfg_ready,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic        [31:0] ts;
	logic        [31:0] te;
	logic signed [31:0] t_exp;

	// temperature as it must follow from the fine value shown beside it
	always_comb begin
		ts    = {fine_temperature[29:0], 2'b00} + fine_temperature + TEMP_ROUND;
		te    = ts + (ts[31] ? TEMP_TRUNC_BIAS : 32'd0);
		t_exp = $signed(te) >>> 8;
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(temperature)
			&& $stable(fine_temperature) && $stable(humidity))
		else $error("result changed while stalled");

	// requests are refused only while a result is waiting
	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	// humidity within its clamp
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity <= HUM_MAX)
		else $error("humidity beyond clamp");

	// temperature and fine temperature belong together
	a_temp_fine: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature == t_exp)
		else $error("temperature does not match fine temperature");

endmodule

bind temp_humidity_compensation thc_checker u_thc_checker (.*);
`default_nettype wire

// File: sim/compensation_checker.sv
`timescale 1ns / 1ps
module compensation_checker
	import thc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [19:0]        raw_temperature,
	input  logic [15:0]        raw_humidity,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] temperature,
	input  logic signed [31:0] fine_temperature,
	input  logic [16:0]        humidity,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 results_seen
);

	localparam logic [31:0] FINE_OFFSET = 32'd76800;
	localparam logic [31:0] X_ROUND     = 32'd16384;
	localparam logic [31:0] Y_OFFSET    = 32'd32768;
	localparam logic [31:0] Y_BIAS      = 32'd2097152;
	localparam logic [31:0] Y_ROUND     = 32'd8192;
	localparam logic [31:0] HUM_CEILING = 32'd419430400;
	localparam logic [31:0] T_ROUND     = 32'd128;
	localparam int          PRINT_CAP   = 40;

	thc_cal_t cal;
	thc_out_t expected_readings[$];
	thc_out_t want;
	int errs = 0;
	int seen = 0;

	// arithmetic shift of a 32-bit two's complement word
	function automatic logic [31:0] sra(input logic [31:0] x, input int n);
		return $unsigned($signed(x) >>> n);
	endfunction

	// integer compensation, every step wrapping at 32 bits
	function automatic thc_out_t compensate_reading(input logic [19:0] rt, input logic [15:0] rh,
			input thc_cal_t c);
		logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
		logic [31:0] a, d, v1, v2, fine, tsum, temp, v, x, y, s;
		thc_out_t r;
		t1 = {16'd0, c.t1};
		t2 = {{16{c.t2[15]}}, c.t2};
		t3 = {{16{c.t3[15]}}, c.t3};
		h1 = {24'd0, c.h1};
		h2 = {{16{c.h2[15]}}, c.h2};
		h3 = {24'd0, c.h3};
		h4 = {{20{c.h4[11]}}, c.h4};
		h5 = {{20{c.h5[11]}}, c.h5};
		h6 = {{24{c.h6[7]}}, c.h6};

		// temperature terms
		a = {15'd0, rt[19:3]} - (t1 << 1);
		v1 = sra(a * t2, 11);
		d = {16'd0, rt[19:4]} - t1;
		v2 = sra(sra(d * d, 12) * t3, 14);
		fine = v1 + v2;

		// hundredths of a degree, division truncating toward zero
		tsum = fine * 32'd5 + T_ROUND;
		if (tsum[31])
			temp = 32'd0 - ((32'd0 - tsum) >> 8);
		else
			temp = tsum >> 8;

		// humidity from the fine temperature of this same sample
		v = fine - FINE_OFFSET;
		x = ({16'd0, rh} << 14) - (h4 << 20) - (h5 * v);
		x = sra(x + X_ROUND, 15);
		y = sra(v * h6, 10) * (sra(v * h3, 11) + Y_OFFSET);
		y = sra(y, 10) + Y_BIAS;
		y = sra(y * h2 + Y_ROUND, 14);
		v = x * y;
		s = sra(v, 15);
		v = v - sra(sra(s * s, 7) * h1, 4);
		if (v[31])
			v = 32'd0;
		else if (v > HUM_CEILING)
			v = HUM_CEILING;

		r.temperature = temp;
		r.fine_temperature = fine;
		r.humidity = v[28:12];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (errs < PRINT_CAP)
			$display("mismatch at %0t ns: %s", $time, what);
		errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal = '0;
			expected_readings.delete();
		end else begin
			// result channel against the oldest prediction
			if (out_valid && out_ready) begin
				seen++;
				if (expected_readings.size() == 0) begin
					report_mismatch($sformatf("result with nothing outstanding, temperature %0d",
						temperature));
				end else begin
					want = expected_readings.pop_front();
					if (temperature !== want.temperature)
						report_mismatch($sformatf("temperature %0d, expected %0d",
							temperature, $signed(want.temperature)));
					if (fine_temperature !== want.fine_temperature)
						report_mismatch($sformatf("fine temperature %0d, expected %0d",
							fine_temperature, $signed(want.fine_temperature)));
					if (humidity !== want.humidity)
						report_mismatch($sformatf("humidity %0d, expected %0d",
							humidity, want.humidity));
				end
			end
			// accepted request
			if (in_valid && in_ready)
				expected_readings.push_back(compensate_reading(raw_temperature, raw_humidity, cal));
			// calibration write, bits above each register dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEMP_CAL_ONE:      cal.t1 = cfg_data[15:0];
					REG_TEMP_CAL_TWO:      cal.t2 = cfg_data[15:0];
					REG_TEMP_CAL_THREE:    cal.t3 = cfg_data[15:0];
					REG_HUM_CAL_ONE:       cal.h1 = cfg_data[7:0];
					REG_HUM_CAL_TWO:       cal.h2 = cfg_data[15:0];
					REG_HUM_CAL_THREE:     cal.h3 = cfg_data[7:0];
					REG_HUM_CAL_FOUR_FIVE: begin
						cal.h4 = cfg_data[23:12];
						cal.h5 = cfg_data[11:0];
					end
					REG_HUM_CAL_SIX:       cal.h6 = cfg_data[7:0];
					default: ;
				endcase
			end
		end
		fail_count <= errs;
		pending <= expected_readings.size();
		results_seen <= seen;
	end

endmodule

// File: sim/temp_humidity_compensation_tb.sv
`timescale 1ns / 1ps
module temp_humidity_compensation_tb;
	import thc_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int LATENCY       = 17;
	localparam int RANDOM_SETS   = 6;
	localparam int ITEMS_PER_SET = 72;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [19:0]        raw_temperature;
	logic [15:0]        raw_humidity;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] temperature;
	logic signed [31:0] fine_temperature;
	logic [16:0]        humidity;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [3:0]         cfg_index;
	logic [23:0]        cfg_data;

	int fail_count;
	int pending;
	int results_seen;
	int send_idle_odds;
	int recv_stall_odds;
	int stall_left = 0;
	int cycles = 0;
	int items_sent = 0;
	int cal_sets = 0;
	int writes_done = 0;

	temp_humidity_compensation dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_temperature(raw_temperature),
		.raw_humidity(raw_humidity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.temperature(temperature),
		.fine_temperature(fine_temperature),
		.humidity(humidity),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	compensation_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_temperature(raw_temperature),
		.raw_humidity(raw_humidity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.temperature(temperature),
		.fine_temperature(fine_temperature),
		.humidity(humidity),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.results_seen(results_seen)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (recv_stall_odds != 0 && $urandom_range(1, recv_stall_odds) == 1) begin
			stall_left <= $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding", cycles, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	// one sensor request, optionally preceded by an idle burst
	task automatic send_reading(input logic [19:0] rt, input logic [15:0] rh);
		if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_temperature <= rt;
		raw_humidity <= rh;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		writes_done++;
	endtask

	// full calibration set, junk above every register narrower than the data word
	task automatic load_cal(input thc_cal_t c);
		logic [7:0]  junk8;
		logic [15:0] junk16;
		junk8 = 8'($urandom);
		junk16 = 16'($urandom);
		write_reg(REG_TEMP_CAL_ONE, {junk8, c.t1});
		write_reg(REG_TEMP_CAL_TWO, {junk8, c.t2});
		write_reg(REG_TEMP_CAL_THREE, {junk8, c.t3});
		write_reg(REG_HUM_CAL_ONE, {junk16, c.h1});
		write_reg(REG_HUM_CAL_TWO, {junk8, c.h2});
		write_reg(REG_HUM_CAL_THREE, {junk16, c.h3});
		write_reg(REG_HUM_CAL_FOUR_FIVE, {c.h4, c.h5});
		write_reg(REG_HUM_CAL_SIX, {junk16, c.h6});
		// index past the register map must change nothing
		write_reg(4'($urandom_range(int'(REG_HUM_CAL_SIX) + 1, 2 ** CFG_INDEX_W - 1)),
			24'($urandom));
		cfg_valid <= 1'b0;
		cal_sets++;
	endtask

	function automatic thc_cal_t make_cal(input int t1, input int t2, input int t3, input int h1,
			input int h2, input int h3, input int h4, input int h5, input int h6);
		thc_cal_t c;
		c.t1 = 16'(t1);
		c.t2 = 16'(t2);
		c.t3 = 16'(t3);
		c.h1 = 8'(h1);
		c.h2 = 16'(h2);
		c.h3 = 8'(h3);
		c.h4 = 12'(h4);
		c.h5 = 12'(h5);
		c.h6 = 8'(h6);
		return c;
	endfunction

	// mode 0 near a typical part, 1 anything at all, 2 a field-by-field mix
	function automatic int pick(input int typical, input int spread, input int mode);
		if (mode == 0 || (mode == 2 && $urandom_range(0, 1) == 1))
			return typical - spread + int'($urandom_range(0, 2 * spread));
		return int'($urandom);
	endfunction

	function automatic thc_cal_t random_cal(input int mode);
		return make_cal(pick(27504, 500, mode), pick(26435, 1000, mode), pick(-1000, 200, mode),
			pick(75, 20, mode), pick(362, 50, mode), pick(5, 5, mode), pick(313, 40, mode),
			pick(50, 20, mode), pick(30, 10, mode));
	endfunction

	// corners of both raw fields, including both humidity clamps
	task automatic send_corners();
		send_reading(20'd0, 16'd0);
		send_reading(20'hFFFFF, 16'hFFFF);
		send_reading(20'd0, 16'hFFFF);
		send_reading(20'hFFFFF, 16'd0);
		send_reading(20'd440000, 16'd30000);
	endtask

	task automatic send_random_reading();
		logic [19:0] rt;
		logic [15:0] rh;
		rt = 20'($urandom);
		rh = 16'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				rt = 20'($urandom_range(350000, 600000));
				rh = 16'($urandom_range(15000, 45000));
			end
			8: rt = $urandom_range(0, 1) ? 20'hFFFFF - 20'($urandom_range(0, 15))
				: 20'($urandom_range(0, 15));
			9: rh = $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 15))
				: 16'($urandom_range(0, 15));
			default: ;
		endcase
		send_reading(rt, rh);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_temperature = '0;
		raw_humidity = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_odds = 4;
		recv_stall_odds = 4;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// calibration still at its reset value
		send_reading(20'd0, 16'd0);
		send_reading(20'hFFFFF, 16'hFFFF);
		wait_drained();

		// typical part
		load_cal(make_cal(27504, 26435, -1000, 75, 362, 0, 313, 50, 30));
		send_reading(20'd519888, 16'd27000);
		send_reading(20'd440000, 16'd0);
		send_reading(20'd440000, 16'hFFFF);
		send_corners();
		wait_drained();

		// every calibration field at its top and then its bottom
		load_cal(make_cal(65535, 32767, 32767, 255, 32767, 255, 2047, 2047, 127));
		send_corners();
		wait_drained();
		load_cal(make_cal(0, -32768, -32768, 0, -32768, 0, -2048, -2048, -128));
		send_corners();

		// random calibration sets, the last one with no idling at all
		for (int s = 0; s < RANDOM_SETS; s++) begin
			wait_drained();
			load_cal(random_cal(s % 3));
			if (s == RANDOM_SETS - 1) begin
				send_idle_odds = 0;
				recv_stall_odds = 0;
			end else begin
				send_idle_odds = 4 * $urandom_range(0, 2);
				recv_stall_odds = 4 * $urandom_range(0, 2);
			end
			repeat (ITEMS_PER_SET) send_random_reading();
		end

		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);

		$display("%0d samples sent, %0d results checked, %0d calibration sets, %0d register writes",
			items_sent, results_seen, cal_sets, writes_done);
		$display("raw field corners, extreme and random calibration, stray register indexes");
		if (pending != 0)
			$display("%0d results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
